@@ rtl/core/bsca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsca_pkg
// Types, codes and helpers shared by the split and coalesce allocator core.
// ----------------------------------------------------------------------------
package bsca_pkg;

  localparam int FIELD_W = 10;
  localparam int DEF_MEM_WORDS = 1024;
  localparam int DEF_HEADER_WORDS = 4;

  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_SPLIT  = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [FIELD_W-1:0] block_index;
    logic [FIELD_W-1:0] request_length;
    logic [FIELD_W-1:0] prev_link;
    logic [FIELD_W-1:0] next_link;
  } cmd_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] data_start;
    logic [FIELD_W-1:0] allocated_words;
    logic [FIELD_W-1:0] overhead_words;
  } res_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] prev;
    logic [FIELD_W-1:0] next;
    logic               is_free;
  } hdr_t;

  typedef struct packed {
    logic               we;
    logic [FIELD_W-1:0] waddr;
    hdr_t               wdata;
    logic [FIELD_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SP_A,
    S_SP_B,
    S_SP_C,
    S_F_A,
    S_F_P,
    S_F_NU,
    S_F_N,
    S_G_P,
    S_G_NU,
    S_DONE
  } state_t;

  // remainder of a link value by the memory depth, restoring subtract steps
  function automatic logic [FIELD_W-1:0] fold_addr(input logic [FIELD_W-1:0] a,
                                                   input int unsigned words);
    logic [23:0] r;
    logic [23:0] m;
    r = 24'(a);
    for (int k = 6; k >= 0; k--) begin
      m = 24'(words) << k;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[FIELD_W-1:0];
  endfunction

endpackage

@@ rtl/core/bsca_hdr_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsca_hdr_mem
// Header store: one write and one registered read per cycle, with
// forwarding of a write that lands on the entry being read.
// ----------------------------------------------------------------------------
module bsca_hdr_mem
  import bsca_pkg::*;
#(
  parameter int MEM_WORDS = DEF_MEM_WORDS
) (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output hdr_t     rdata
);

  localparam int AW = $clog2(MEM_WORDS);

  hdr_t          mem_q [MEM_WORDS];
  hdr_t          rd_q;
  hdr_t          fwd_data;
  logic [AW-1:0] fwd_addr;
  logic          fwd_valid;
  logic [AW-1:0] raddr_q;
  logic [AW-1:0] waddr_i;
  logic [AW-1:0] raddr_i;

  assign waddr_i = AW'(fold_addr(req.waddr, MEM_WORDS));
  assign raddr_i = AW'(fold_addr(req.raddr, MEM_WORDS));

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[waddr_i] <= req.wdata;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk) begin
    fwd_data <= req.wdata;
    fwd_addr <= waddr_i;
    raddr_q  <= raddr_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= req.we;
    end
  end

  assign rdata = (fwd_valid && (fwd_addr == raddr_q)) ? fwd_data : rd_q;

endmodule

@@ rtl/core/bsca_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsca_ctrl
// Command sequencer: read-modify-write steps on the header store for
// create, split and free with coalescing, plus the word counters.
// ----------------------------------------------------------------------------
module bsca_ctrl
  import bsca_pkg::*;
#(
  parameter int HEADER_WORDS = DEF_HEADER_WORDS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd_data,
  input  logic      out_free,
  output logic      out_load,
  output res_item_t out_data,
  output mem_req_t  mem_req,
  input  hdr_t      mem_rdata
);

  localparam logic [FIELD_W-1:0] HW = FIELD_W'(HEADER_WORDS);

  state_t             state;
  state_t             state_next;
  logic [1:0]         cmd_q;
  logic [FIELD_W-1:0] idx_q;
  logic [FIELD_W-1:0] req_q;
  hdr_t               h_q;
  hdr_t               h_next;
  logic [FIELD_W-1:0] alloc_cnt;
  logic [FIELD_W-1:0] alloc_cnt_next;
  logic [FIELD_W-1:0] ovh_cnt;
  logic [FIELD_W-1:0] ovh_cnt_next;
  logic [FIELD_W-1:0] nidx;
  logic               cmd_fire;

  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign nidx      = idx_q + req_q + HW;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      alloc_cnt <= '0;
      ovh_cnt   <= '0;
    end else begin
      state     <= state_next;
      alloc_cnt <= alloc_cnt_next;
      ovh_cnt   <= ovh_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    h_q <= h_next;
    if (cmd_fire) begin
      cmd_q <= cmd_data.command;
      idx_q <= cmd_data.block_index;
      req_q <= cmd_data.request_length;
    end
  end

  always_comb begin
    hdr_t               nmod;
    logic [11:0]        need;
    logic [FIELD_W-1:0] nlen;
    state_next     = state;
    h_next         = h_q;
    alloc_cnt_next = alloc_cnt;
    ovh_cnt_next   = ovh_cnt;
    mem_req        = '0;
    mem_req.raddr  = idx_q;
    out_load       = 1'b0;
    out_data       = '0;
    nmod           = mem_rdata;
    need           = 12'(req_q) + 12'(HEADER_WORDS) + 12'd1;
    nlen           = mem_rdata.length - req_q - HW;
    case (state)
      S_IDLE: begin
        mem_req.raddr = cmd_data.block_index;
        if (cmd_fire) begin
          case (cmd_data.command)
            CMD_CREATE: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = cmd_data.block_index;
              mem_req.wdata = '{length: cmd_data.request_length,
                                prev: cmd_data.prev_link,
                                next: cmd_data.next_link,
                                is_free: 1'b1};
              state_next    = S_DONE;
            end
            CMD_SPLIT: state_next = S_SP_A;
            CMD_FREE:  state_next = S_F_A;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_SP_A: begin
        h_next = mem_rdata;
        if (12'(mem_rdata.length) < need) begin
          // whole block given out
          mem_req.we            = 1'b1;
          mem_req.waddr         = idx_q;
          mem_req.wdata         = mem_rdata;
          mem_req.wdata.is_free = 1'b0;
          alloc_cnt_next        = alloc_cnt + mem_rdata.length;
          ovh_cnt_next          = ovh_cnt + HW;
          state_next            = S_DONE;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = nidx;
          mem_req.wdata = '{length: nlen, prev: idx_q, next: mem_rdata.next,
                            is_free: 1'b1};
          if (mem_rdata.next != '0) begin
            mem_req.raddr = mem_rdata.next;
            state_next    = S_SP_B;
          end else begin
            state_next    = S_SP_C;
          end
        end
      end
      S_SP_B: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = h_q.next;
        mem_req.wdata      = mem_rdata;
        mem_req.wdata.prev = nidx;
        state_next         = S_SP_C;
      end
      S_SP_C: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_q;
        mem_req.wdata = '{length: req_q, prev: mem_rdata.prev, next: nidx,
                          is_free: 1'b0};
        alloc_cnt_next = alloc_cnt + req_q;
        ovh_cnt_next   = ovh_cnt + HW;
        state_next     = S_DONE;
      end
      S_F_A: begin
        h_next = mem_rdata;
        if (!mem_rdata.is_free) begin
          mem_req.we            = 1'b1;
          mem_req.waddr         = idx_q;
          mem_req.wdata         = mem_rdata;
          mem_req.wdata.is_free = 1'b1;
          alloc_cnt_next        = alloc_cnt - mem_rdata.length;
          ovh_cnt_next          = ovh_cnt - HW;
        end
        if (mem_rdata.prev != '0) begin
          mem_req.raddr = mem_rdata.prev;
          state_next    = S_F_P;
        end else if (mem_rdata.next != '0) begin
          mem_req.raddr = mem_rdata.next;
          state_next    = S_F_N;
        end else begin
          state_next    = S_DONE;
        end
      end
      S_F_P, S_G_P: begin
        mem_req.raddr = h_q.next;
        if (mem_rdata.is_free) begin
          // merge into free predecessor
          mem_req.we    = 1'b1;
          mem_req.waddr = h_q.prev;
          mem_req.wdata = '{length: mem_rdata.length + h_q.length + HW,
                            prev: mem_rdata.prev, next: h_q.next,
                            is_free: mem_rdata.is_free};
          if (h_q.next != '0) begin
            state_next = (state == S_F_P) ? S_F_NU : S_G_NU;
          end else begin
            state_next = S_DONE;
          end
        end else if ((state == S_F_P) && (h_q.next != '0)) begin
          state_next = S_F_N;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F_NU, S_F_N: begin
        if (state == S_F_NU) begin
          nmod.prev     = h_q.prev;
          mem_req.we    = 1'b1;
          mem_req.waddr = h_q.next;
          mem_req.wdata = nmod;
        end
        if (nmod.is_free) begin
          // follow-on merge of the free successor
          h_next = nmod;
          if (nmod.prev != '0) begin
            mem_req.raddr = nmod.prev;
            state_next    = S_G_P;
          end else begin
            state_next    = S_DONE;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_G_NU: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = h_q.next;
        mem_req.wdata      = mem_rdata;
        mem_req.wdata.prev = h_q.prev;
        state_next         = S_DONE;
      end
      S_DONE: begin
        out_data.data_start      = (cmd_q == CMD_SPLIT) ? (idx_q + HW) : '0;
        out_data.allocated_words = alloc_cnt;
        out_data.overhead_words  = ovh_cnt;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> (state != S_IDLE))
    else $error("accepted command did not start");

  a_idle_counters_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> ($stable(alloc_cnt) && $stable(ovh_cnt)))
    else $error("counter changed while idle");

  a_done_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && !out_free) |=> (state == S_DONE))
    else $error("result dropped while output full");

  a_idle_write_is_create: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && (state == S_IDLE)) |-> (cmd_fire && (cmd_data.command == CMD_CREATE)))
    else $error("header write while idle without create");

endmodule

@@ rtl/core/bsca_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsca_out_reg
// Result holding register on the output channel.
// ----------------------------------------------------------------------------
module bsca_out_reg
  import bsca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  res_item_t data,
  output logic      free,
  output logic      valid,
  input  logic      ready,
  output res_item_t q
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= data;
    end
  end

endmodule

@@ rtl/core/block_split_and_coalesce_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_split_and_coalesce_allocator_core
// Boundary-tag block allocator: create, split and free with coalescing.
// ----------------------------------------------------------------------------
// One command is in work at a time. Header accesses are reads of the
// single header memory, which has a registered read, and most reads are
// followed by a write back; create writes its header without a read and
// unknown codes touch no header. Split and free take more steps, free
// more when neighbors are merged. The result sits in an output register,
// so the next command is taken while it waits.
// Headers are undefined until created; no clearing pass runs after reset.
module block_split_and_coalesce_allocator_core
  import bsca_pkg::*;
#(
  parameter int MEM_WORDS    = DEF_MEM_WORDS,
  parameter int HEADER_WORDS = DEF_HEADER_WORDS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd_data,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_data
);

  mem_req_t  mem_req;
  hdr_t      mem_rdata;
  logic      out_free;
  logic      out_load;
  res_item_t out_data;

  bsca_hdr_mem #(
    .MEM_WORDS(MEM_WORDS)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  bsca_ctrl #(
    .HEADER_WORDS(HEADER_WORDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data (cmd_data),
    .out_free (out_free),
    .out_load (out_load),
    .out_data (out_data),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata)
  );

  bsca_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .data (out_data),
    .free (out_free),
    .valid(res_valid),
    .ready(res_ready),
    .q    (res_data)
  );

endmodule

@@ tb/alloc_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_scoreboard_pkg
// Header store mirror and result checker for the split and coalesce
// allocator. Every accepted command is applied to a private copy of the
// headers and counters; the predicted status is queued and compared with
// each result the block hands over.
// ----------------------------------------------------------------------------
package alloc_scoreboard_pkg;
  import bsca_pkg::*;

  localparam int HDR_WORDS = DEF_HEADER_WORDS;

  class alloc_scoreboard;
    hdr_t               heads[DEF_MEM_WORDS];
    bit                 made[DEF_MEM_WORDS];
    int                 made_list[$];
    logic [FIELD_W-1:0] alloc_cnt;
    logic [FIELD_W-1:0] ovh_cnt;
    res_item_t          status_q[$];
    int                 errors;

    function new();
      alloc_cnt = '0;
      ovh_cnt = '0;
      errors = 0;
      foreach (made[i]) begin
        made[i] = 1'b0;
        heads[i] = '0;
      end
    endfunction

    function void put_header(int a, logic [FIELD_W-1:0] len, logic [FIELD_W-1:0] prv,
                             logic [FIELD_W-1:0] nxt, logic fr);
      heads[a].length = len;
      heads[a].prev = prv;
      heads[a].next = nxt;
      heads[a].is_free = fr;
      if (!made[a]) begin
        made[a] = 1'b1;
        made_list.push_back(a);
      end
    endfunction

    function logic [FIELD_W-1:0] apply_split(int idx, int req);
      int blen;
      int give;
      int nidx;
      int nlen;
      int succ;
      blen = int'(heads[idx].length);
      give = req;
      if (blen < req + HDR_WORDS + 1) begin
        give = blen;
      end else begin
        nidx = (idx + req + HDR_WORDS) % DEF_MEM_WORDS;
        nlen = blen - req - HDR_WORDS;
        put_header(nidx, FIELD_W'(nlen), FIELD_W'(idx), heads[idx].next, 1'b1);
        succ = int'(heads[idx].next);
        if (succ != 0) begin
          heads[succ].prev = FIELD_W'(nidx);
        end
        heads[idx].next = FIELD_W'(nidx);
      end
      heads[idx].length = FIELD_W'(give);
      heads[idx].is_free = 1'b0;
      ovh_cnt = ovh_cnt + FIELD_W'(HDR_WORDS);
      alloc_cnt = alloc_cnt + FIELD_W'(give);
      return FIELD_W'(idx + HDR_WORDS);
    endfunction

    // second pass is the single follow-on merge of a free successor
    function void apply_free(int idx);
      int cur;
      int prv;
      int nxt;
      int sum;
      cur = idx;
      for (int pass = 0; pass < 2; pass++) begin
        prv = int'(heads[cur].prev);
        nxt = int'(heads[cur].next);
        if (!heads[cur].is_free) begin
          heads[cur].is_free = 1'b1;
          alloc_cnt = alloc_cnt - heads[cur].length;
          ovh_cnt = ovh_cnt - FIELD_W'(HDR_WORDS);
        end
        if (prv != 0 && heads[prv].is_free) begin
          sum = int'(heads[prv].length) + int'(heads[cur].length) + HDR_WORDS;
          heads[prv].length = FIELD_W'(sum);
          heads[prv].next = FIELD_W'(nxt);
          if (nxt != 0) begin
            heads[nxt].prev = FIELD_W'(prv);
          end
        end
        if (pass == 0 && nxt != 0 && heads[nxt].is_free) begin
          cur = nxt;
        end else begin
          break;
        end
      end
    endfunction

    function void apply_command(cmd_item_t c);
      res_item_t r;
      int idx;
      idx = int'(c.block_index) % DEF_MEM_WORDS;
      r.data_start = '0;
      case (c.command)
        CMD_CREATE: put_header(idx, c.request_length, c.prev_link, c.next_link, 1'b1);
        CMD_SPLIT: r.data_start = apply_split(idx, int'(c.request_length));
        CMD_FREE: apply_free(idx);
        default: ;
      endcase
      r.allocated_words = alloc_cnt;
      r.overhead_words = ovh_cnt;
      status_q.push_back(r);
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: start=%0d alloc=%0d ovh=%0d", $time,
                 got.data_start, got.allocated_words, got.overhead_words);
        return;
      end
      want = status_q.pop_front();
      if (got.data_start !== want.data_start || got.allocated_words !== want.allocated_words
          || got.overhead_words !== want.overhead_words) begin
        errors++;
        $display("%0t mismatch: exp start=%0d alloc=%0d ovh=%0d, got start=%0d alloc=%0d ovh=%0d",
                 $time, want.data_start, want.allocated_words, want.overhead_words,
                 got.data_start, got.allocated_words, got.overhead_words);
      end
    endfunction
  endclass

endpackage

@@ tb/block_split_and_coalesce_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_split_and_coalesce_allocator_core_tb
// Drives create, split, free and unknown commands into the allocator core
// with random gaps on both channels and checks every result against a
// mirrored header store. Commands only ever touch headers that have been
// created, and links always point at created headers, so no undefined header is read.
// ----------------------------------------------------------------------------
module block_split_and_coalesce_allocator_core_tb;
  import bsca_pkg::*;
  import alloc_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  cmd_item_t cmd_data;
  logic      res_valid;
  logic      res_ready;
  res_item_t res_data;

  alloc_scoreboard sb = new();
  int  n_accepted = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  block_split_and_coalesce_allocator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        sb.apply_command(cmd_data);
        n_accepted++;
      end
      if (res_valid && res_ready) begin
        sb.check_result(res_data);
      end
    end
  end

  // receiver: random stalls, one long hold-off once traffic is going
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && n_accepted >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_ready <= 1'b0;
      end else if (calm) begin
        res_ready <= 1'b1;
      end else begin
        res_ready <= ($urandom_range(99) >= 24);
      end
    end
  end

  initial begin
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic issue_command(input cmd_item_t c);
    while (!calm && $urandom_range(99) < 24) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_data <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue_fields(input logic [1:0] cmd, input int idx, input int len,
                              input int prv, input int nxt);
    cmd_item_t c;
    c.command = cmd;
    c.block_index = FIELD_W'(idx);
    c.request_length = FIELD_W'(len);
    c.prev_link = FIELD_W'(prv);
    c.next_link = FIELD_W'(nxt);
    issue_command(c);
  endtask

  function automatic int pick_header(bit want_free);
    int a;
    a = 0;
    repeat (8) begin
      a = sb.made_list[$urandom_range(sb.made_list.size() - 1)];
      if (sb.heads[a].is_free == want_free) return a;
    end
    return a;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_link();
    if (sb.made_list.size() == 0 || $urandom_range(3) == 0) return '0;
    return FIELD_W'(sb.made_list[$urandom_range(sb.made_list.size() - 1)]);
  endfunction

  function automatic cmd_item_t next_random_command();
    cmd_item_t c;
    int roll;
    int a;
    int blen;
    c.command = 2'($urandom_range(3));
    c.block_index = FIELD_W'($urandom_range(1023));
    c.request_length = FIELD_W'($urandom_range(1023));
    c.prev_link = FIELD_W'($urandom_range(1023));
    c.next_link = FIELD_W'($urandom_range(1023));
    roll = $urandom_range(99);
    if (sb.made_list.size() == 0 || roll < 10) begin
      c.command = CMD_CREATE;
      c.prev_link = ($urandom_range(9) < 7) ? '0 : pick_link();
      c.next_link = ($urandom_range(9) < 7) ? '0 : pick_link();
    end else if (roll < 45) begin
      a = pick_header(1'b1);
      blen = int'(sb.heads[a].length);
      c.command = CMD_SPLIT;
      c.block_index = FIELD_W'(a);
      case ($urandom_range(4))
        0: c.request_length = FIELD_W'($urandom_range(1023));
        1: c.request_length = FIELD_W'((blen >= HDR_WORDS) ? blen - HDR_WORDS : 0);
        2: c.request_length = FIELD_W'($urandom_range(blen));
        default: c.request_length = FIELD_W'($urandom_range(blen / 4));
      endcase
    end else if (roll < 82) begin
      c.command = CMD_FREE;
      c.block_index = FIELD_W'(pick_header(1'b0));
    end else if (roll < 97) begin
      c.command = CMD_CREATE;
      c.prev_link = pick_link();
      c.next_link = pick_link();
    end else begin
      c.command = 2'd3;
    end
    return c;
  endfunction

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue_fields(2'd3, 1023, 1023, 1023, 1023);
    issue_fields(CMD_CREATE, 0, 1023, 0, 0);
    issue_fields(CMD_SPLIT, 0, 0, 0, 0);
    issue_fields(CMD_SPLIT, 4, 1023, 1023, 1023);
    issue_fields(CMD_FREE, 4, 0, 0, 0);
    issue_fields(CMD_FREE, 0, 0, 0, 0);
    issue_fields(CMD_FREE, 0, 1023, 1023, 1023);
    issue_fields(CMD_CREATE, 1023, 1023, 0, 0);
    // remainder address and data start wrap past the top of memory
    issue_fields(CMD_SPLIT, 1023, 10, 0, 0);
    issue_fields(CMD_SPLIT, 1023, 2, 0, 0);
    issue_fields(CMD_FREE, 1023, 0, 0, 0);
    issue_fields(CMD_CREATE, 100, 50, 0, 0);
    issue_fields(CMD_SPLIT, 100, 10, 0, 0);
    issue_fields(CMD_SPLIT, 114, 10, 0, 0);
    issue_fields(CMD_FREE, 100, 0, 0, 0);
    issue_fields(CMD_FREE, 114, 0, 0, 0);
    issue_fields(CMD_CREATE, 200, 15, 0, 0);
    issue_fields(CMD_SPLIT, 200, 11, 0, 0);
    issue_fields(CMD_CREATE, 300, 16, 200, 1023);
    issue_fields(CMD_SPLIT, 300, 11, 0, 0);
    issue_fields(CMD_FREE, 200, 0, 0, 0);
    issue_fields(CMD_FREE, 300, 0, 0, 0);
    issue_fields(2'd3, 0, 0, 0, 0);
    issue_fields(CMD_CREATE, 512, 0, 1023, 0);
    issue_fields(CMD_SPLIT, 512, 0, 0, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 1000 && i < 1200);
      if (i == 900) begin
        cmd_valid <= 1'b0;
        do @(negedge clk); while (sb.status_q.size() != 0);
      end
      issue_command(next_random_command());
    end
    calm = 1'b0;
    cmd_valid <= 1'b0;
    do @(negedge clk); while (sb.status_q.size() != 0);
    repeat (20) @(negedge clk);

    if (sb.errors == 0 && sb.status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
